/* sv/source_text_tokenizer_assert.svh */
// assertion macros for the source text tokenizer checker
// no dependencies; included by the checker file only
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define STT_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("source_text_tokenizer check failed");

// next-cycle implication, disabled while reset is asserted
`define STT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("source_text_tokenizer check failed");

`endif

/* sv/stt_pkg.sv */
// shared types, token codes, character codes and keyword helpers of the tokenizer
// no dependencies; used by the scanner, the output queue, the top level and the checker
`default_nettype none

package stt_pkg;

  localparam int unsigned MAX_SOURCE_BYTES_DEF = 65536;
  localparam int unsigned RESULTS_MAX          = 3;
  localparam int unsigned QUEUE_DEPTH          = 4;

  localparam logic [15:0] LIM16   = 16'hFFFF;
  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  // scanner modes
  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_EQ,
    MODE_BANG,
    MODE_LT,
    MODE_GT,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_COMMENT
  } mode_t;

  // token kinds
  typedef logic [4:0] kind_t;
  localparam kind_t KIND_LPAREN    = 5'd0;
  localparam kind_t KIND_RPAREN    = 5'd1;
  localparam kind_t KIND_LBRACE    = 5'd2;
  localparam kind_t KIND_RBRACE    = 5'd3;
  localparam kind_t KIND_COMMA     = 5'd4;
  localparam kind_t KIND_SEMI      = 5'd5;
  localparam kind_t KIND_PLUS      = 5'd6;
  localparam kind_t KIND_MINUS     = 5'd7;
  localparam kind_t KIND_STAR      = 5'd8;
  localparam kind_t KIND_SLASH     = 5'd9;
  localparam kind_t KIND_EQUAL     = 5'd10;
  localparam kind_t KIND_EQEQ      = 5'd11;
  localparam kind_t KIND_BANGEQ    = 5'd12;
  localparam kind_t KIND_LESS      = 5'd13;
  localparam kind_t KIND_LESSEQ    = 5'd14;
  localparam kind_t KIND_GREATER   = 5'd15;
  localparam kind_t KIND_GREATEREQ = 5'd16;
  localparam kind_t KIND_NUMBER    = 5'd17;
  localparam kind_t KIND_IDENT     = 5'd18;
  localparam kind_t KIND_KEYWORD0  = 5'd19;
  localparam kind_t KIND_EOF       = 5'd25;

  // character codes
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_BANG   = "!";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_0      = "0";
  localparam logic [7:0] CH_9      = "9";
  localparam logic [7:0] CH_LA     = "a";
  localparam logic [7:0] CH_LZ     = "z";
  localparam logic [7:0] CH_UA     = "A";
  localparam logic [7:0] CH_UZ     = "Z";
  localparam logic [7:0] CH_UNDER  = "_";

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
    logic [30:0] value;
  } token_t;

  // tokens caused by one source byte, valid from slot 0 up to count-1
  typedef struct packed {
    logic [1:0]                   count;
    token_t [RESULTS_MAX-1:0]     tok;
  } bundle_t;

  function automatic token_t mk_token(input kind_t k, input logic [15:0] st,
                                      input logic [15:0] len, input logic [15:0] ln,
                                      input logic [15:0] col, input logic [30:0] val);
    token_t t;
    t.kind   = k;
    t.start  = st;
    t.length = len;
    t.line   = ln;
    t.column = col;
    t.value  = val;
    return t;
  endfunction

  // keyword lengths: fn let return if else while
  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd0:    r = 3'd2;
      3'd1:    r = 3'd3;
      3'd2:    r = 3'd6;
      3'd3:    r = 3'd2;
      3'd4:    r = 3'd4;
      3'd5:    r = 3'd5;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  // keyword character at a given index, zero past the end
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] idx);
    logic [47:0] w;
    logic [7:0]  r;
    case (k)
      3'd0:    w = {"fn", 32'h0};
      3'd1:    w = {"let", 24'h0};
      3'd2:    w = "return";
      3'd3:    w = {"if", 32'h0};
      3'd4:    w = {"else", 16'h0};
      3'd5:    w = {"while", 8'h0};
      default: w = 48'h0;
    endcase
    case (idx)
      3'd0:    r = w[47:40];
      3'd1:    r = w[39:32];
      3'd2:    r = w[31:24];
      3'd3:    r = w[23:16];
      3'd4:    r = w[15:8];
      3'd5:    r = w[7:0];
      default: r = 8'h0;
    endcase
    return r;
  endfunction

  // drop keywords that no longer match after one more identifier character
  function automatic logic [5:0] hits_step(input logic [5:0] hits, input logic [7:0] c,
                                           input logic in_range, input logic [2:0] idx);
    logic [5:0] h;
    h = hits;
    for (int k = 0; k < 6; k++) begin
      if (!in_range || (idx >= kw_len(3'(k))) || (kw_char(3'(k), idx) != c)) begin
        h[k] = 1'b0;
      end
    end
    return h;
  endfunction

  // identifier or the first keyword still matching at this length
  function automatic kind_t ident_kind(input logic [5:0] hits, input logic [15:0] len);
    kind_t r;
    r = KIND_IDENT;
    for (int k = 5; k >= 0; k--) begin
      if (hits[k] && (len == {13'd0, kw_len(3'(k))})) begin
        r = KIND_KEYWORD0 + 5'(k);
      end
    end
    return r;
  endfunction

  function automatic logic has_pending(input mode_t m);
    return (m == MODE_SLASH) || (m == MODE_EQ) || (m == MODE_LT) || (m == MODE_GT) ||
           (m == MODE_NUMBER) || (m == MODE_IDENT);
  endfunction

  // kind of the token held pending in a mode
  function automatic kind_t pend_kind(input mode_t m, input logic [5:0] hits,
                                      input logic [15:0] len);
    kind_t r;
    case (m)
      MODE_SLASH:  r = KIND_SLASH;
      MODE_EQ:     r = KIND_EQUAL;
      MODE_LT:     r = KIND_LESS;
      MODE_GT:     r = KIND_GREATER;
      MODE_NUMBER: r = KIND_NUMBER;
      default:     r = ident_kind(hits, len);
    endcase
    return r;
  endfunction

  // acc * 10 + d, saturating at 2^31-1
  function automatic logic [30:0] acc_step(input logic [30:0] acc, input logic [3:0] d);
    logic [30:0] th;
    logic [34:0] p;
    th = (d > 4'd7) ? 31'd214748363 : 31'd214748364;
    p  = 35'({acc, 3'b000}) + 35'({acc, 1'b0}) + 35'(d);
    return (acc > th) ? NUM_MAX : p[30:0];
  endfunction

endpackage

`default_nettype wire

/* sv/stt_if.sv */
// valid/ready channel interfaces for source bytes and tokens
// no dependencies
`default_nettype none

interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       end_of_source;

  modport source (output valid, output src_byte, output end_of_source, input ready);
  modport sink   (input valid, input src_byte, input end_of_source, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic [30:0] number_value;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output line_number, output column_number, output number_value,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start, input token_length,
                  input line_number, input column_number, input number_value,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

/* sv/stt_scan.sv */
// input register and single-pass scanner: one source byte in, a bundle of tokens out
// depends on stt_pkg and stt_in_if
`default_nettype none

module stt_scan #(
  parameter int unsigned MAX_SOURCE_BYTES = stt_pkg::MAX_SOURCE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  stt_in_if.sink           in_ch,
  input  logic             q_space,
  output logic             bund_we,
  output stt_pkg::bundle_t bund
);
  import stt_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_SOURCE_BYTES + 1);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eos_r;

  // scanner state
  mode_t            mode_r,   mode_nxt;
  logic [POS_W-1:0] pos_r,    pos_nxt;
  logic [POS_W-1:0] pstart_r, pstart_nxt;
  logic [15:0]      line_r,   line_nxt;
  logic [15:0]      col_r,    col_nxt;
  logic [30:0]      acc_r,    acc_nxt;
  logic [5:0]       hits_r,   hits_nxt;

  logic             fire;
  logic [7:0]       c;
  logic             take, is_nl, is_dig, is_alp;
  logic [15:0]      line_a, col_a;
  logic [POS_W-1:0] len_c, len_e, pos_n;
  logic [15:0]      len16_c, len16_e;
  mode_t            mode_c;
  logic [POS_W-1:0] pstart_c;
  logic [30:0]      acc_c;
  logic [5:0]       hits_c;
  logic             do_flush, do_fresh, two_v, punct_v;
  kind_t            two_kind, punct_kind;
  token_t           tok_a, tok_b, tok_c, tok2;
  logic             v_a, v_b, v_c, v2;
  bundle_t          bund_n;

  function automatic logic [15:0] sat16(input logic [POS_W-1:0] v);
    return (32'(v) > 32'(LIM16)) ? LIM16 : 16'(v);
  endfunction

  assign fire        = s1_valid_r && q_space;
  assign in_ch.ready = !s1_valid_r || q_space;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.src_byte;
      s1_eos_r  <= in_ch.end_of_source;
    end
  end

  // scan one byte, then handle end of source
  always_comb begin
    c      = s1_byte_r;
    take   = pos_r < POS_W'(MAX_SOURCE_BYTES);
    is_nl  = (c == CH_NL);
    is_dig = (c >= CH_0) && (c <= CH_9);
    is_alp = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
             (c == CH_UNDER);

    // line and column after this byte
    line_a = line_r;
    col_a  = col_r;
    if (take) begin
      if (is_nl) begin
        if (line_r != LIM16) line_a = line_r + 16'd1;
        col_a = 16'd1;
      end else if (col_r != LIM16) begin
        col_a = col_r + 16'd1;
      end
    end

    len_c    = pos_r - pstart_r;
    len16_c  = sat16(len_c);
    mode_c   = mode_r;
    pstart_c = pstart_r;
    acc_c    = acc_r;
    hits_c   = hits_r;
    do_flush = 1'b0;
    do_fresh = 1'b0;
    two_v    = 1'b0;
    two_kind = KIND_EQEQ;

    // continue or end the pending token
    if (take) begin
      case (mode_r)
        MODE_COMMENT: begin
          do_fresh = is_nl;
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode_c = MODE_COMMENT;
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        MODE_EQ, MODE_LT, MODE_GT: begin
          two_kind = (mode_r == MODE_EQ) ? KIND_EQEQ :
                     (mode_r == MODE_LT) ? KIND_LESSEQ : KIND_GREATEREQ;
          if (c == CH_EQ) begin
            two_v = 1'b1;
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        MODE_BANG: begin
          two_kind = KIND_BANGEQ;
          if (c == CH_EQ) begin
            two_v = 1'b1;
          end else begin
            do_fresh = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_dig) begin
            acc_c = acc_step(acc_r, c[3:0]);
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_dig || is_alp) begin
            hits_c = hits_step(hits_r, c, (32'(len_c) < 32'd6), len_c[2:0]);
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        default: begin
          do_fresh = 1'b1;
        end
      endcase
    end

    if (two_v || do_flush) mode_c = MODE_IDLE;

    // start a new token at this byte
    punct_v    = 1'b0;
    punct_kind = KIND_LPAREN;
    if (do_fresh) begin
      pstart_c = pos_r;
      mode_c   = MODE_IDLE;
      case (c)
        CH_LPAREN: begin punct_v = 1'b1; punct_kind = KIND_LPAREN; end
        CH_RPAREN: begin punct_v = 1'b1; punct_kind = KIND_RPAREN; end
        CH_LBRACE: begin punct_v = 1'b1; punct_kind = KIND_LBRACE; end
        CH_RBRACE: begin punct_v = 1'b1; punct_kind = KIND_RBRACE; end
        CH_COMMA:  begin punct_v = 1'b1; punct_kind = KIND_COMMA;  end
        CH_SEMI:   begin punct_v = 1'b1; punct_kind = KIND_SEMI;   end
        CH_PLUS:   begin punct_v = 1'b1; punct_kind = KIND_PLUS;   end
        CH_MINUS:  begin punct_v = 1'b1; punct_kind = KIND_MINUS;  end
        CH_STAR:   begin punct_v = 1'b1; punct_kind = KIND_STAR;   end
        CH_SLASH:  mode_c = MODE_SLASH;
        CH_EQ:     mode_c = MODE_EQ;
        CH_BANG:   mode_c = MODE_BANG;
        CH_LT:     mode_c = MODE_LT;
        CH_GT:     mode_c = MODE_GT;
        default: begin
          if (is_dig) begin
            mode_c = MODE_NUMBER;
            acc_c  = {27'd0, c[3:0]};
          end else if (is_alp) begin
            mode_c = MODE_IDENT;
            hits_c = hits_step(6'h3F, c, 1'b1, 3'd0);
          end
        end
      endcase
    end

    // token ended by this byte, then a two-char operator or punctuation
    v_a   = do_flush;
    tok_a = mk_token(pend_kind(mode_r, hits_r, len16_c), 16'(pstart_r), len16_c,
                     line_r, col_r, (mode_r == MODE_NUMBER) ? acc_r : 31'd0);
    tok_b = two_v ? mk_token(two_kind, 16'(pstart_r), 16'd2, line_a, col_a, 31'd0)
                  : mk_token(punct_kind, 16'(pos_r), 16'd1, line_a, col_a, 31'd0);

    // end of source: flush what is pending, then end of file
    pos_n   = pos_r + POS_W'(take);
    len_e   = pos_n - pstart_c;
    len16_e = sat16(len_e);
    v2      = s1_eos_r && has_pending(mode_c);
    tok2    = mk_token(pend_kind(mode_c, hits_c, len16_e), 16'(pstart_c), len16_e,
                       line_a, col_a, (mode_c == MODE_NUMBER) ? acc_c : 31'd0);
    v_b     = two_v || punct_v || v2;
    if (!(two_v || punct_v)) tok_b = tok2;
    v_c     = s1_eos_r;
    tok_c   = mk_token(KIND_EOF, 16'(pos_n), 16'd0, line_a, col_a, 31'd0);

    // pack into consecutive slots
    bund_n.count  = 2'(v_a) + 2'(v_b) + 2'(v_c);
    bund_n.tok[0] = v_a ? tok_a : (v_b ? tok_b : tok_c);
    bund_n.tok[1] = (v_a && v_b) ? tok_b : tok_c;
    bund_n.tok[2] = tok_c;

    // next state, back to reset after end of source
    if (s1_eos_r) begin
      mode_nxt   = MODE_IDLE;
      pos_nxt    = '0;
      pstart_nxt = '0;
      line_nxt   = 16'd1;
      col_nxt    = 16'd1;
      acc_nxt    = 31'd0;
      hits_nxt   = 6'h3F;
    end else begin
      mode_nxt   = mode_c;
      pos_nxt    = pos_n;
      pstart_nxt = pstart_c;
      line_nxt   = line_a;
      col_nxt    = col_a;
      acc_nxt    = acc_c;
      hits_nxt   = hits_c;
    end
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      pstart_r <= '0;
      line_r   <= 16'd1;
      col_r    <= 16'd1;
      acc_r    <= 31'd0;
      hits_r   <= 6'h3F;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      acc_r    <= acc_nxt;
      hits_r   <= hits_nxt;
    end
  end

  assign bund_we = fire && (bund_n.count != 2'd0);
  assign bund    = bund_n;

endmodule

`default_nettype wire

/* sv/stt_outq.sv */
// bundle queue and serializer: stores token bundles and sends one token per transaction
// depends on stt_pkg and stt_out_if
`default_nettype none

module stt_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             bund_we,
  input  stt_pkg::bundle_t bund,
  output logic             q_space,
  stt_out_if.source        out_ch
);
  import stt_pkg::*;

  localparam int unsigned QA_W = $clog2(QUEUE_DEPTH);

  bundle_t         q_mem [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QA_W:0]   cnt_r;
  logic [1:0]      sub_r;
  logic            out_valid_r;
  token_t          out_tok_r;
  logic            out_last_r;

  bundle_t head;
  logic    q_nempty, load, head_last, pop;

  assign q_space   = cnt_r < (QA_W + 1)'(QUEUE_DEPTH);
  assign q_nempty  = cnt_r != '0;
  assign head      = q_mem[rd_ptr_r];
  assign head_last = (sub_r == (head.count - 2'd1));
  assign load      = q_nempty && (!out_valid_r || out_ch.ready);
  assign pop       = load && head_last;

  // queue storage
  always_ff @(posedge clk) begin
    if (bund_we) begin
      q_mem[wr_ptr_r] <= bund;
    end
  end

  // pointers, fill count and slot index within the head bundle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      sub_r    <= 2'd0;
    end else begin
      if (bund_we) wr_ptr_r <= wr_ptr_r + QA_W'(1);
      if (pop)     rd_ptr_r <= rd_ptr_r + QA_W'(1);
      cnt_r <= cnt_r + (QA_W + 1)'(bund_we) - (QA_W + 1)'(pop);
      if (load) sub_r <= head_last ? 2'd0 : sub_r + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= q_nempty;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok_r  <= head.tok[sub_r];
      out_last_r <= head_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.token_kind    = out_tok_r.kind;
  assign out_ch.token_start   = out_tok_r.start;
  assign out_ch.token_length  = out_tok_r.length;
  assign out_ch.line_number   = out_tok_r.line;
  assign out_ch.column_number = out_tok_r.column;
  assign out_ch.number_value  = out_tok_r.value;
  assign out_ch.last_of_run   = out_last_r;

endmodule

`default_nettype wire

/* sv/source_text_tokenizer.sv */
// channel  dir  payload                                              flow
// in_ch    in   src_byte, end_of_source                              valid / ready
// out_ch   out  token_kind, token_start, token_length, line_number,  valid / ready
//               column_number, number_value, last_of_run
//
// one source byte is accepted per cycle while the bundle queue has space; a byte is held in
// the input register, scanned combinationally into the bundle queue, and its tokens leave
// through the output register; a byte yields zero to three tokens, and the output register
// sends one token per cycle while out_ch.ready is high; the 4-entry bundle queue absorbs bursts
// in_ch.ready falls only while the bundle queue is full; reset is synchronous, active low
// top level of the tokenizer: wires the scanner to the output queue
// depends on stt_pkg, stt_if, stt_scan and stt_outq
`default_nettype none

module source_text_tokenizer #(
  parameter int unsigned MAX_SOURCE_BYTES = stt_pkg::MAX_SOURCE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  stt_in_if.sink    in_ch,
  stt_out_if.source out_ch
);
  import stt_pkg::*;

  bundle_t bund;
  logic    bund_we;
  logic    q_space;

  // scanner
  stt_scan #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_space (q_space),
    .bund_we (bund_we),
    .bund    (bund)
  );

  // bundle queue and token output
  stt_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .bund_we (bund_we),
    .bund    (bund),
    .q_space (q_space),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

/* sv/stt_check.sv */
// port checker of the tokenizer, attached to the top level by bind
// depends on stt_pkg, source_text_tokenizer and the assertion macro header
`default_nettype none
`include "source_text_tokenizer_assert.svh"

module stt_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_kind,
  input logic [15:0] out_length,
  input logic [15:0] out_line,
  input logic [15:0] out_column,
  input logic [30:0] out_value,
  input logic        out_last
);
  import stt_pkg::*;

  // a stalled token stays offered
  `STT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // end of file closes the run of its byte and has no length
  `STT_ASSERT_IMPLY(a_eof_shape, clk, rst_n, out_valid && (out_kind == KIND_EOF), out_last && (out_length == 16'd0))

  // only number tokens carry a value
  `STT_ASSERT_IMPLY(a_value_number_only, clk, rst_n, out_valid && (out_kind != KIND_NUMBER), out_value == 31'd0)

  // line and column count from one
  `STT_ASSERT_IMPLY(a_pos_nonzero, clk, rst_n, out_valid, (out_line != 16'd0) && (out_column != 16'd0))

endmodule

bind source_text_tokenizer stt_check u_stt_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.token_kind),
  .out_length (out_ch.token_length),
  .out_line   (out_ch.line_number),
  .out_column (out_ch.column_number),
  .out_value  (out_ch.number_value),
  .out_last   (out_ch.last_of_run)
);

`default_nettype wire
